[hw/rtl/rfc_pkg.sv]
// shared types and constants for the rtu frame checker
package rfc_pkg;

	// frame limits
	localparam int unsigned MinFrame      = 4;
	localparam int unsigned CountCap      = 256;
	localparam int unsigned MaxFrameDflt  = 256;
	localparam int unsigned CountW        = 9;

	// crc-16/modbus
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_LONG  = 2'd2,
		ST_CRC   = 2'd3
	} status_t;

	// one received byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} rx_beat_t;

	// one frame verdict
	typedef struct packed {
		status_t    status;
		logic [7:0] station_address;
		logic [7:0] pdu_length;
	} res_beat_t;

endpackage

[hw/rtl/rtu_frame_checker.sv]
// top level: rtu frame length and crc-16/modbus checker
//
// Input channel rx carries one frame byte per beat (rx_valid, rx_stall,
// rx_beat), with last_byte set on the final byte of a frame. The output
// channel res carries one verdict per frame (status, station address and
// pdu length), given only for the final byte.
// A beat is taken at a clock edge with valid high and stall low.
// Each accepted byte is held in an input register, the frame state and
// crc are updated from it, and on the final byte the verdict lands in a
// result register; a final byte can wait in the input register while a
// stalled result is pending. One byte per cycle is sustained while no
// final byte waits; the crc step is a combinational byte-wise update.
// While a result waits under res_stall, non-final bytes keep flowing; a
// final byte waits in the input register and rx_stall rises until the
// pending result is taken.
// Reset (arst_n low) clears both valid flags and the byte count and sets
// the crc to its initial value, so the next byte starts a new frame.
module rtu_frame_checker #(
	parameter int unsigned MAX_FRAME = rfc_pkg::MaxFrameDflt
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  rfc_pkg::rx_beat_t  rx_beat,
	output logic               res_valid,
	input  logic               res_stall,
	output rfc_pkg::res_beat_t res_beat
);

	logic               valid_s1;
	rfc_pkg::rx_beat_t  beat_s1;
	logic               advance;
	logic               res_free;
	logic               res_valid_q;
	rfc_pkg::res_beat_t res_q;
	rfc_pkg::res_beat_t res_comb;

	// handshake: a final byte needs a free result slot
	assign res_free = !res_valid_q || !res_stall;
	assign advance  = valid_s1 && (!beat_s1.last_byte || res_free);
	assign rx_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			beat_s1 <= rx_beat;
		end
	end

	// frame state and verdict
	rfc_frame_state #(
		.MAX_FRAME (MAX_FRAME)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat    (beat_s1),
		.res     (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && beat_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.last_byte) begin
			res_q <= res_comb;
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

endmodule

[hw/rtl/rfc_crc_byte.sv]
// byte-wise crc-16/modbus update, reflected, eight shift steps
module rfc_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	// xor byte in, then shift out eight bits
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ rfc_pkg::CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

[hw/rtl/rfc_frame_state.sv]
// per-frame state: byte count, address, delay line, crc and verdict
module rfc_frame_state #(
	parameter int unsigned MAX_FRAME = rfc_pkg::MaxFrameDflt
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  rfc_pkg::rx_beat_t   beat,
	output rfc_pkg::res_beat_t  res
);

	localparam logic [rfc_pkg::CountW-1:0] Cap =
		rfc_pkg::CountW'(rfc_pkg::CountCap);
	localparam logic [rfc_pkg::CountW-1:0] MinN =
		rfc_pkg::CountW'(rfc_pkg::MinFrame);
	localparam logic [rfc_pkg::CountW-1:0] MaxN =
		rfc_pkg::CountW'(MAX_FRAME);

	logic [15:0]                crc_q;
	logic [rfc_pkg::CountW-1:0] count_q;
	logic [7:0]                 d0_q;
	logic [7:0]                 d1_q;
	logic [7:0]                 first_q;

	logic [15:0]                crc_fed;
	logic [15:0]                crc_next;
	logic [rfc_pkg::CountW-1:0] count_next;
	logic [7:0]                 first_next;
	logic [15:0]                rx_crc;
	rfc_pkg::status_t           status;

	// crc over the byte leaving the delay line
	rfc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (d1_q),
		.crc_out (crc_fed)
	);

	// next-state values for this byte
	always_comb begin
		crc_next   = (count_q >= rfc_pkg::CountW'(2)) ? crc_fed : crc_q;
		first_next = (count_q == '0) ? beat.data_byte : first_q;
		count_next = (count_q < Cap) ? count_q + rfc_pkg::CountW'(1) : Cap;
		rx_crc     = {beat.data_byte, d0_q};
	end

	// verdict, checks in priority order
	always_comb begin
		if (count_next < MinN) begin
			status = rfc_pkg::ST_SHORT;
		end else if (count_next >= MaxN) begin
			status = rfc_pkg::ST_LONG;
		end else if (crc_next != rx_crc) begin
			status = rfc_pkg::ST_CRC;
		end else begin
			status = rfc_pkg::ST_OK;
		end
		res.status = status;
		if (status == rfc_pkg::ST_OK) begin
			res.station_address = first_next;
			res.pdu_length      = 8'(count_next - rfc_pkg::CountW'(3));
		end else begin
			res.station_address = '0;
			res.pdu_length      = '0;
		end
	end

	// state update, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= rfc_pkg::CrcInit;
			count_q <= '0;
			d0_q    <= '0;
			d1_q    <= '0;
			first_q <= '0;
		end else if (advance) begin
			if (beat.last_byte) begin
				crc_q   <= rfc_pkg::CrcInit;
				count_q <= '0;
				d0_q    <= '0;
				d1_q    <= '0;
				first_q <= '0;
			end else begin
				crc_q   <= crc_next;
				count_q <= count_next;
				d0_q    <= beat.data_byte;
				d1_q    <= d0_q;
				first_q <= first_next;
			end
		end
	end

endmodule

[hw/rtl/rfc_checker.sv]
// port-level checks for the rtu frame checker, bound to the top level
module rfc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_stall,
	input  logic               res_valid,
	input  logic               res_stall,
	input  rfc_pkg::res_beat_t res_beat
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_beat))
		else $error("result beat changed under stall");

	// input backpressure only comes from a stalled pending result
	a_rx_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall)
		else $error("rx stall without pending stalled result");

	// failed frames report zero address and length
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.status != rfc_pkg::ST_OK
		|-> res_beat.station_address == 8'd0 && res_beat.pdu_length == 8'd0)
		else $error("failed frame with nonzero fields");

	// good frames carry at least one pdu byte and fit the frame limit
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.status == rfc_pkg::ST_OK
		|-> res_beat.pdu_length >= 8'd1 && res_beat.pdu_length <= 8'd252)
		else $error("ok frame with impossible pdu length");

endmodule

bind rtu_frame_checker rfc_checker u_rfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_stall  (rx_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_beat  (res_beat)
);
